### hw/rtl/sha_pkg.sv
// SHA-256 byte-stream hasher: shared types, constants and round functions.
// Depends on nothing; used by every module under hw/rtl.
package sha_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned WORDS_PER_BLOCK = 16;
	localparam int unsigned ROUNDS = 64;
	localparam int unsigned LEN_OFFSET = 56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word_0;
		logic [31:0] digest_word_1;
		logic [31:0] digest_word_2;
		logic [31:0] digest_word_3;
		logic [31:0] digest_word_4;
		logic [31:0] digest_word_5;
		logic [31:0] digest_word_6;
		logic [31:0] digest_word_7;
	} out_beat_t;

	// Start/init and busy/done between the control FSM and the compression core
	typedef struct packed {
		logic start;
		logic init_chain;
	} core_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[r];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

### hw/rtl/sha_buf.sv
// Block buffer: 64-byte memory, one byte write port, one 32-bit word read port.
// Depends on sha_pkg.
module sha_buf
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        wr_en,
	input  logic [5:0]  wr_addr,
	input  logic [7:0]  wr_data,
	input  logic [3:0]  rd_word,
	output logic [31:0] rd_data
);

	// sixteen big-endian words; byte 0 of a word sits in bits 31..24
	logic [31:0] mem_q [WORDS_PER_BLOCK];

	// byte write into its lane of the addressed word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
		end
	end

	// registered word read
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_word];
	end

endmodule

### hw/rtl/sha_core.sv
// Compression core: reads block words from the buffer, expands the schedule in
// a 16-word window, runs one round per cycle, adds into the chaining state.
// Depends on sha_pkg.
module sha_core
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  core_cmd_t   cmd,
	output core_sts_t   sts,
	output logic [3:0]  rd_word,
	input  logic [31:0] rd_data,
	output logic [31:0] chain [8]
);

	typedef enum logic [3:0] {
		C_IDLE  = 4'b0001,
		C_LOAD  = 4'b0010,
		C_ROUND = 4'b0100,
		C_ADD   = 4'b1000
	} cstate_t;

	cstate_t     state_q;
	logic [6:0]  cnt_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [31:0] w_cur, w_new, t1, t2;

	// address the buffer word fetched during the load sweep
	assign rd_word = cnt_q[3:0];

	// word used this round: from the buffer for the first sixteen, else schedule
	assign w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	assign w_cur = (cnt_q < 7'd16) ? w_q[cnt_q[3:0]] : w_new;
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(cnt_q[5:0]) + w_cur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				C_IDLE: if (cmd.start) begin
					state_q <= C_LOAD;
					cnt_q   <= '0;
				end
				C_LOAD: begin
					// the buffer read is registered: run to 16
					if (cnt_q == 7'd16) begin
						state_q <= C_ROUND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_ROUND: begin
					if (cnt_q == 7'(ROUNDS - 1)) begin
						state_q <= C_ADD;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				C_ADD: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else if (state_q == C_ADD) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end else if (state_q == C_IDLE && cmd.init_chain) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == C_LOAD) begin
			if (cnt_q != 7'd0) w_q[cnt_q[3:0] - 4'd1] <= rd_data;
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == C_ROUND) begin
			if (cnt_q >= 7'd16) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= w_new;
			end else if (cnt_q == 7'd15) begin
				// window already holds words 0..15 in place
				w_q <= w_q;
			end
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign chain    = h_q;
	assign sts.busy = (state_q != C_IDLE);
	assign sts.done = (state_q == C_ADD);

`ifndef NO_ASSERTIONS
	// a start is only issued while idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == C_IDLE) else $error("start while busy");
	// the add step always follows the last round
	a_add_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ADD |-> $past(state_q) == C_ROUND) else $error("bad add");
	// done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> !sts.done) else $error("done held");
`endif

endmodule

### hw/rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 byte-stream hasher top level: handshake, padding sequencer, counters.
// Depends on sha_pkg, sha_buf and sha_core.
//
// One input beat carries one message byte, an end mark, or both. A byte that
// does not complete a block is written in S_WRITE before the next beat is
// taken. A byte that fills the block starts a compression: a start, a buffer
// load, 64 rounds at one round per cycle, and an add, in that order. An end
// beat writes the padding one byte per cycle through the single buffer write
// port, runs one or two compressions, and then presents the digest straight
// from the chaining registers; the next input beat is taken once the digest
// has left.
module sha256_byte_stream_hasher_top
	import sha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_WRITE = 7'b0000010,
		S_PAD   = 7'b0000100,
		S_COMP  = 7'b0001000,
		S_WAIT  = 7'b0010000,
		S_OUT   = 7'b0100000,
		S_LEN   = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        fin_q;
	logic        byte_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [2:0]  len_q;
	core_cmd_t   cmd;
	core_sts_t   sts;
	logic [3:0]  rd_word;
	logic [31:0] rd_data;
	logic [31:0] chain [8];
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_data;
	logic        accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// buffer write port: message byte, pad byte or zero, length byte
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q;
		wr_data = data_q;
		case (state_q)
			S_WRITE: wr_en = byte_q;
			S_PAD: begin
				wr_en   = 1'b1;
				wr_data = last_q ? 8'h00 : PAD_BYTE;
			end
			S_LEN: begin
				wr_en   = 1'b1;
				wr_addr = {3'b111, len_q};
				wr_data = bits_q[8 * (7 - len_q) +: 8];
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign cmd.start      = (state_q == S_COMP);
	assign cmd.init_chain = (state_q == S_OUT) && !out_stall;

	// sequencer; last_q marks that the 0x80 has been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			fin_q   <= 1'b0;
			byte_q  <= 1'b0;
			data_q  <= '0;
			last_q  <= 1'b0;
			len_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) begin
					byte_q  <= in_data.byte_present;
					fin_q   <= in_data.end_of_message;
					data_q  <= in_data.data_byte;
					last_q  <= 1'b0;
					if (in_data.byte_present || in_data.end_of_message) state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (byte_q) begin
						fill_q <= fill_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
					if (byte_q && fill_q == 6'd63) state_q <= S_COMP;
					else if (fin_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_PAD: begin
					last_q <= 1'b1;
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q <= S_COMP;
					end else if (fill_q == 6'(LEN_OFFSET - 1)) begin
						len_q   <= '0;
						state_q <= S_LEN;
					end
				end
				// len_q holds at 7 to mark the final compression
				S_LEN: begin
					if (len_q == 3'd7) begin
						fill_q  <= '0;
						state_q <= S_COMP;
					end else begin
						len_q <= len_q + 3'd1;
					end
				end
				S_COMP: state_q <= S_WAIT;
				S_WAIT: if (sts.done) begin
					if (!fin_q) state_q <= S_IDLE;
					else if (len_q == 3'd7) begin
						state_q   <= S_OUT;
						out_valid <= 1'b1;
					end else state_q <= S_PAD;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
					fill_q    <= '0;
					bits_q    <= '0;
					len_q     <= '0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// digest: chaining registers hold still while the core idles in S_OUT
	assign out_data = {chain[0], chain[1], chain[2], chain[3],
		chain[4], chain[5], chain[6], chain[7]};

	sha_buf u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_word (rd_word),
		.rd_data (rd_data)
	);

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.rd_word (rd_word),
		.rd_data (rd_data),
		.chain   (chain)
	);

`ifndef NO_ASSERTIONS
	// no input beat is taken while a compression runs
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !accept) else $error("accept during compression");
	// the buffer is never written while the core reads it
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !wr_en) else $error("buffer write during compression");
	// a digest only appears after the length bytes were written
	a_out_after_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> len_q == 3'd7) else $error("digest without length");
`endif

endmodule
